/* src/grm_pkg.sv */
// shared types, constants and direction functions for the grid ray marcher
package grm_pkg;

	localparam int MAP_W      = 32;
	localparam int MAP_H      = 32;
	localparam int TILE_SHIFT = 6;
	localparam int ANGLE_BITS = 10;
	localparam int FRAC_BITS  = 8;

	localparam int MAP_XW    = $clog2(MAP_W);
	localparam int MAP_YW    = $clog2(MAP_H);
	localparam int MAP_CELLS = MAP_W * MAP_H;
	localparam int MAP_AW    = MAP_XW + MAP_YW;

	localparam int CELL_W = 5;
	localparam int TILE_W = 8;
	localparam int XY_W   = 19;
	localparam int ANG_W  = 10;
	localparam int DIST_W = 10;

	// sample position: room for the coordinate, one step of overshoot and the sign
	localparam int POS_W  = XY_W + 2;
	localparam int STEP_W = FRAC_BITS + 2;
	localparam int SH     = FRAC_BITS + TILE_SHIFT;

	localparam logic [DIST_W-1:0] MAX_DIST_RESET = DIST_W'(1000);

	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [CELL_W-1:0] cell_x;
		logic [CELL_W-1:0] cell_y;
		logic [TILE_W-1:0] cell_value;
		logic [XY_W-1:0]   start_x;
		logic [XY_W-1:0]   start_y;
		logic [ANG_W-1:0]  ray_angle;
	} in_item_t;

	typedef struct packed {
		logic              hit;
		logic [XY_W-1:0]   hit_x;
		logic [XY_W-1:0]   hit_y;
		logic [DIST_W-1:0] distance;
		logic [TILE_W-1:0] wall_code;
	} out_item_t;

	// classified request handed from front to back
	typedef struct packed {
		logic                     cmd;
		logic                     wr_ok;
		logic [MAP_AW-1:0]        wr_addr;
		logic [TILE_W-1:0]        wr_value;
		logic [XY_W-1:0]          start_x;
		logic [XY_W-1:0]          start_y;
		logic signed [STEP_W-1:0] dir_x;
		logic signed [STEP_W-1:0] dir_y;
	} job_t;

	typedef logic [64:0][15:0] qw_t;

	// quarter-wave sine table, q15, built by the integer recurrence
	function automatic qw_t build_qw();
		logic [63:0] prev;
		logic [63:0] cur;
		logic [63:0] nxt;
		logic [63:0] twice;
		qw_t t;
		prev = 64'd0;
		cur  = 64'd26350943;
		t[0] = 16'd0;
		t[1] = 16'((cur + 64'd16384) >> 15);
		for (int k = 2; k <= 64; k++) begin
			twice = (64'd1073418433 * cur + (64'd1 << 28)) >> 29;
			nxt   = (twice >= prev) ? twice - prev : 64'd0;
			prev  = cur;
			cur   = nxt;
			t[k]  = 16'((cur + 64'd16384) >> 15);
		end
		return t;
	endfunction

	localparam qw_t QW = build_qw();

	// p covers a quarter turn in 0..16384, result is a q15 magnitude
	function automatic logic [15:0] quarter_sine(input logic [14:0] p);
		logic [6:0]  i;
		logic [7:0]  f;
		logic [15:0] lo;
		logic [15:0] hi;
		logic [15:0] diff;
		logic [23:0] prod;
		logic [15:0] res;
		i = p[14:8];
		f = p[7:0];
		if (i >= 7'd64) begin
			res = QW[64];
		end else begin
			lo = QW[i];
			hi = QW[i + 7'd1];
			if (hi < lo) begin
				res = lo;
			end else begin
				diff = hi - lo;
				prod = 24'(diff) * 24'(f) + 24'd128;
				res  = lo + 16'(prod >> 8);
			end
		end
		return res;
	endfunction

	// unit step component: minus the sine of a 16-bit angle, FRAC_BITS fraction bits
	function automatic logic signed [STEP_W-1:0] neg_sine(input logic [15:0] a16);
		logic [14:0] arg;
		logic [15:0] m;
		logic [16:0] r;
		logic [STEP_W-1:0] mag;
		arg = a16[14] ? (15'd16384 - {1'b0, a16[13:0]}) : {1'b0, a16[13:0]};
		m   = quarter_sine(arg);
		r   = (17'(m) + (17'd1 << (14 - FRAC_BITS))) >> (15 - FRAC_BITS);
		mag = STEP_W'(r);
		return a16[15] ? signed'(mag) : -signed'(mag);
	endfunction

endpackage

/* src/grid_ray_march_core.sv */
// grid ray marcher top level: tile map store with fixed unit-step ray casts
//
// Requests enter through push/full and results leave through empty/pop, both
// behaving like a queue. A request with cmd 0 writes one map tile and gives no
// result; a request with cmd 1 casts a ray and always gives exactly one result
// (hit with point, step count and tile code, or an all-zero miss).
// The front end registers a request and computes the step vector from the
// registered copy, then hands it to a two-deep queue; the back end takes one
// request at a time. A cell write is done as the back end pops it. A cast
// samples from step 1 on and hits at the first step whose tile is non-zero,
// or misses at the first step that leaves the map or reaches max_distance:
// the march issues one map memory read per cycle, bounded by that single
// read port. The front keeps accepting while the back marches.
// After reset the back end zeroes the 1024-entry tile map, one entry a cycle,
// and full stays high until it is done; max_distance resets to 1000 and
// cfg writes are taken at any time (cfg_ready is always high) but should only
// be issued while no cast is in progress. A result not popped holds in the
// output register; the next cast finishes but waits, and the queue fills.
module grid_ray_march_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  grm_pkg::in_item_t               item,
	output logic                            full,
	output logic                            empty,
	input  logic                            pop,
	output grm_pkg::out_item_t              result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [grm_pkg::DIST_W-1:0]      cfg_data
);

	logic [grm_pkg::DIST_W-1:0] max_distance_q;
	logic                       clearing;
	logic                       jobq_full;
	logic                       jobq_push;
	logic                       jobq_empty;
	logic                       jobq_pop;
	grm_pkg::job_t              front_job;
	grm_pkg::job_t              back_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= grm_pkg::MAX_DIST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_distance_q <= cfg_data;
		end
	end

	grm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.hold      (clearing),
		.jobq_full (jobq_full),
		.jobq_push (jobq_push),
		.job       (front_job)
	);

	grm_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (jobq_push),
		.wr_job (front_job),
		.full   (jobq_full),
		.rd_en  (jobq_pop),
		.empty  (jobq_empty),
		.rd_job (back_job)
	);

	grm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.max_distance (max_distance_q),
		.jobq_empty   (jobq_empty),
		.job          (back_job),
		.jobq_pop     (jobq_pop),
		.clearing     (clearing),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule

/* src/grm_front.sv */
// front end: takes requests, classifies them and works out the step vector
module grm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  grm_pkg::in_item_t   item,
	output logic                full,
	input  logic                hold,
	input  logic                jobq_full,
	output logic                jobq_push,
	output grm_pkg::job_t       job
);

	logic              valid_s1;
	grm_pkg::in_item_t item_s1;
	logic [15:0]       a16;
	logic              take;

	assign full      = hold || (valid_s1 && jobq_full);
	assign take      = push && !full;
	assign jobq_push = valid_s1 && !jobq_full;

	always_comb begin
		a16 = 16'(item_s1.ray_angle[grm_pkg::ANGLE_BITS-1:0]) << (16 - grm_pkg::ANGLE_BITS);
		job.cmd      = item_s1.cmd;
		job.wr_ok    = (int'(item_s1.cell_x) < grm_pkg::MAP_W) &&
			(int'(item_s1.cell_y) < grm_pkg::MAP_H);
		job.wr_addr  = {item_s1.cell_y[grm_pkg::MAP_YW-1:0],
			item_s1.cell_x[grm_pkg::MAP_XW-1:0]};
		job.wr_value = item_s1.cell_value;
		job.start_x  = item_s1.start_x;
		job.start_y  = item_s1.start_y;
		// step is (-cos, -sin), cos taken as sine a quarter turn ahead
		job.dir_x    = grm_pkg::neg_sine(a16 + 16'd16384);
		job.dir_y    = grm_pkg::neg_sine(a16);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			item_s1  <= '0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
				item_s1  <= item;
			end else if (jobq_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

/* src/grm_jobq.sv */
// short request queue between front and back
module grm_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  grm_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output logic          empty,
	output grm_pkg::job_t rd_job
);

	grm_pkg::job_t               slots_q [0:grm_pkg::JOBQ_DEPTH-1];
	logic [grm_pkg::JOBQ_AW-1:0] wr_ptr_q;
	logic [grm_pkg::JOBQ_AW-1:0] rd_ptr_q;
	logic [grm_pkg::JOBQ_AW:0]   count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign full   = (count_q == (grm_pkg::JOBQ_AW + 1)'(grm_pkg::JOBQ_DEPTH));
	assign empty  = (count_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			for (int k = 0; k < grm_pkg::JOBQ_DEPTH; k++) begin
				slots_q[k] <= '0;
			end
		end else begin
			if (do_wr) begin
				slots_q[wr_ptr_q] <= wr_job;
				wr_ptr_q <= (wr_ptr_q == grm_pkg::JOBQ_AW'(grm_pkg::JOBQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == grm_pkg::JOBQ_AW'(grm_pkg::JOBQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/grm_back.sv */
// back end: tile map memory, cell writes and the step-by-step march
module grm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [grm_pkg::DIST_W-1:0]        max_distance,
	input  logic                              jobq_empty,
	input  grm_pkg::job_t                     job,
	output logic                              jobq_pop,
	output logic                              clearing,
	output logic                              empty,
	input  logic                              pop,
	output grm_pkg::out_item_t                result
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MARCH,
		ST_DONE
	} state_t;

	state_t                             state_q;
	logic [grm_pkg::MAP_AW-1:0]         clr_q;
	logic signed [grm_pkg::POS_W-1:0]   pos_x_q;
	logic signed [grm_pkg::POS_W-1:0]   pos_y_q;
	logic signed [grm_pkg::STEP_W-1:0]  dir_x_q;
	logic signed [grm_pkg::STEP_W-1:0]  dir_y_q;
	logic [grm_pkg::DIST_W-1:0]         d_q;
	logic                               pend_q;
	logic signed [grm_pkg::POS_W-1:0]   pos_x_s1;
	logic signed [grm_pkg::POS_W-1:0]   pos_y_s1;
	logic [grm_pkg::DIST_W-1:0]         d_s1;
	grm_pkg::out_item_t                 fin_q;
	grm_pkg::out_item_t                 res_q;
	logic                               res_valid_q;

	logic [grm_pkg::TILE_W-1:0]         map_q [0:grm_pkg::MAP_CELLS-1];
	logic [grm_pkg::TILE_W-1:0]         rdata_q;

	logic                               we;
	logic [grm_pkg::MAP_AW-1:0]         wa;
	logic [grm_pkg::TILE_W-1:0]         wd;
	logic                               re;
	logic [grm_pkg::MAP_AW-1:0]         ra;
	logic                               pend_hit;
	logic                               out_x;
	logic                               out_y;
	logic                               stop;
	logic                               slot_free;
	logic                               load_res;

	assign empty    = !res_valid_q;
	assign result   = res_q;
	assign clearing = (state_q == ST_CLEAR);
	assign jobq_pop = (state_q == ST_IDLE) && !jobq_empty;

	always_comb begin
		pend_hit  = pend_q && (rdata_q != '0);
		// negative or beyond the last tile on either axis
		out_x     = pos_x_q[grm_pkg::POS_W-1] ||
			(int'(pos_x_q[grm_pkg::POS_W-2:grm_pkg::SH]) >= grm_pkg::MAP_W);
		out_y     = pos_y_q[grm_pkg::POS_W-1] ||
			(int'(pos_y_q[grm_pkg::POS_W-2:grm_pkg::SH]) >= grm_pkg::MAP_H);
		stop      = (d_q >= max_distance) || out_x || out_y;
		slot_free = !res_valid_q || pop;
		load_res  = (state_q == ST_DONE) && slot_free;
		ra        = {pos_y_q[grm_pkg::SH+grm_pkg::MAP_YW-1:grm_pkg::SH],
			pos_x_q[grm_pkg::SH+grm_pkg::MAP_XW-1:grm_pkg::SH]};
		re        = (state_q == ST_MARCH) && !pend_hit && !stop;
		we        = 1'b0;
		wa        = job.wr_addr;
		wd        = job.wr_value;
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				wd = '0;
			end
			ST_IDLE: begin
				we = jobq_pop && (job.cmd == grm_pkg::CMD_WRITE) && job.wr_ok;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			map_q[wa] <= wd;
		end
		if (re) begin
			rdata_q <= map_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			dir_x_q     <= '0;
			dir_y_q     <= '0;
			d_q         <= '0;
			pend_q      <= 1'b0;
			pos_x_s1    <= '0;
			pos_y_s1    <= '0;
			d_s1        <= '0;
			fin_q       <= '0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_q       <= fin_q;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == grm_pkg::MAP_AW'(grm_pkg::MAP_CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (jobq_pop && (job.cmd == grm_pkg::CMD_CAST)) begin
						// first sample is one step out from the start
						pos_x_q <= signed'(grm_pkg::POS_W'(job.start_x)) +
							grm_pkg::POS_W'(job.dir_x);
						pos_y_q <= signed'(grm_pkg::POS_W'(job.start_y)) +
							grm_pkg::POS_W'(job.dir_y);
						dir_x_q <= job.dir_x;
						dir_y_q <= job.dir_y;
						d_q     <= grm_pkg::DIST_W'(1);
						pend_q  <= 1'b0;
						state_q <= ST_MARCH;
					end
				end
				ST_MARCH: begin
					if (pend_hit) begin
						fin_q.hit       <= 1'b1;
						fin_q.hit_x     <= pos_x_s1[grm_pkg::XY_W-1:0];
						fin_q.hit_y     <= pos_y_s1[grm_pkg::XY_W-1:0];
						fin_q.distance  <= d_s1;
						fin_q.wall_code <= rdata_q;
						pend_q          <= 1'b0;
						state_q         <= ST_DONE;
					end else if (stop) begin
						fin_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ST_DONE;
					end else begin
						// map read in flight, next sample computed alongside
						pos_x_s1 <= pos_x_q;
						pos_y_s1 <= pos_y_q;
						d_s1     <= d_q;
						pend_q   <= 1'b1;
						pos_x_q  <= pos_x_q + grm_pkg::POS_W'(dir_x_q);
						pos_y_q  <= pos_y_q + grm_pkg::POS_W'(dir_y_q);
						d_q      <= d_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* tb/grid_ray_march_checker.sv */
// checker for the grid ray marcher: tracks the tile map, traces rays, compares results
`timescale 1ns / 1ps
module grid_ray_march_checker
	import grm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              full,
	input  in_item_t          item,
	input  logic              pop,
	input  logic              empty,
	input  out_item_t         result,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [DIST_W-1:0] cfg_data,
	output int                errors,
	output int                outstanding,
	output int                rays_checked,
	output int                walls_hit
);

	localparam int GRID_W      = 32;
	localparam int GRID_H      = 32;
	localparam int FRAC        = 8;
	localparam int CELL_SHIFT  = FRAC + 6;
	localparam int ANGLE_SHIFT = 16 - 10;
	localparam int STEP_LIMIT_RESET = 1000;

	logic [7:0]  tile_map [0:GRID_W*GRID_H-1];
	logic [15:0] sine_q15 [0:64];
	int          step_limit;
	out_item_t   predicted_rays [$];

	// quarter wave of sin(k*pi/128) in q15, from the chebyshev recurrence in q30
	function automatic void build_sine_table();
		logic [63:0] s_prev;
		logic [63:0] s_cur;
		logic [63:0] s_twice;
		s_prev = 64'd0;
		s_cur = 64'd26350943;
		sine_q15[0] = 16'd0;
		sine_q15[1] = 16'((s_cur + 64'd16384) >> 15);
		for (int k = 2; k <= 64; k++) begin
			s_twice = (64'd1073418433 * s_cur + (64'd1 << 28)) >> 29;
			s_twice = (s_twice >= s_prev) ? s_twice - s_prev : 64'd0;
			s_prev = s_cur;
			s_cur = s_twice;
			sine_q15[k] = 16'((s_cur + 64'd16384) >> 15);
		end
	endfunction

	// p in 0..16384 spans a quarter turn
	function automatic int unsigned sine_magnitude(input int unsigned p);
		int unsigned idx;
		int unsigned frac;
		int unsigned lo;
		int unsigned hi;
		idx = p >> 8;
		frac = p & 255;
		if (idx >= 64)
			return sine_q15[64];
		lo = sine_q15[idx];
		hi = sine_q15[idx + 1];
		if (hi < lo)
			return lo;
		return lo + (((hi - lo) * frac + 128) >> 8);
	endfunction

	// sine of a 16-bit angle with FRAC fraction bits
	function automatic int signed_sine(input int unsigned a16);
		int unsigned quad;
		int unsigned p;
		int unsigned m;
		int unsigned r;
		quad = (a16 >> 14) & 3;
		p = a16 & 16383;
		m = quad[0] ? sine_magnitude(16384 - p) : sine_magnitude(p);
		r = (m + (1 << (14 - FRAC))) >> (15 - FRAC);
		return quad[1] ? -int'(r) : int'(r);
	endfunction

	function automatic out_item_t trace_ray(input in_item_t req);
		out_item_t   res;
		longint      sx;
		longint      sy;
		longint      dx;
		longint      dy;
		longint      px;
		longint      py;
		longint      cx;
		longint      cy;
		int unsigned a16;
		res = '0;
		sx = req.start_x;
		sy = req.start_y;
		a16 = int'(req.ray_angle) << ANGLE_SHIFT;
		dx = -longint'(signed_sine((a16 + 16384) & 16'hFFFF));
		dy = -longint'(signed_sine(a16 & 16'hFFFF));
		// the origin itself is never looked at
		for (longint d = 1; d < step_limit; d++) begin
			px = sx + d * dx;
			py = sy + d * dy;
			if (px < 0 || py < 0)
				return res;
			cx = px >>> CELL_SHIFT;
			cy = py >>> CELL_SHIFT;
			if (cx >= GRID_W || cy >= GRID_H)
				return res;
			if (tile_map[cy * GRID_W + cx] != 8'd0) begin
				res.hit = 1'b1;
				res.hit_x = px[18:0];
				res.hit_y = py[18:0];
				res.distance = d[9:0];
				res.wall_code = tile_map[cy * GRID_W + cx];
				return res;
			end
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic compare_ray(input out_item_t want, input out_item_t got);
		if (got.hit !== want.hit)
			report_mismatch($sformatf("ray %0d hit: expected %0h, got %0h",
				rays_checked, want.hit, got.hit));
		if (got.hit_x !== want.hit_x)
			report_mismatch($sformatf("ray %0d hit_x: expected %0h, got %0h",
				rays_checked, want.hit_x, got.hit_x));
		if (got.hit_y !== want.hit_y)
			report_mismatch($sformatf("ray %0d hit_y: expected %0h, got %0h",
				rays_checked, want.hit_y, got.hit_y));
		if (got.distance !== want.distance)
			report_mismatch($sformatf("ray %0d distance: expected %0d, got %0d",
				rays_checked, want.distance, got.distance));
		if (got.wall_code !== want.wall_code)
			report_mismatch($sformatf("ray %0d wall_code: expected %0h, got %0h",
				rays_checked, want.wall_code, got.wall_code));
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < GRID_W * GRID_H; i++)
				tile_map[i] = 8'd0;
			build_sine_table();
			step_limit = STEP_LIMIT_RESET;
			predicted_rays.delete();
			errors = 0;
			rays_checked = 0;
			walls_hit = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				step_limit = cfg_data;
			// results first, so a ray accepted on this edge cannot match itself
			if (pop && !empty) begin
				if (predicted_rays.size() == 0) begin
					report_mismatch("result with no ray waiting");
				end else begin
					want = predicted_rays.pop_front();
					compare_ray(want, result);
					if (want.hit)
						walls_hit++;
					rays_checked++;
				end
			end
			if (push && !full) begin
				if (item.cmd == CMD_WRITE)
					tile_map[{item.cell_y, item.cell_x}] = item.cell_value;
				else
					predicted_rays.insert(predicted_rays.size(), trace_ray(item));
			end
		end
		outstanding = predicted_rays.size();
	end

endmodule

/* tb/grid_ray_march_core_test.sv */
// top of the grid ray marcher testbench: stimulus, idling, watchdog and verdict
`timescale 1ns / 1ps
module grid_ray_march_core_test;
	import grm_pkg::*;

	localparam int ITEM_TARGET = 600;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 1500;
	localparam logic [XY_W-1:0] MID = 19'd262144;
	localparam logic [XY_W-1:0] NEAR_CORNER = 19'd520000;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	in_item_t          item;
	logic              full;
	logic              empty;
	logic              pop;
	out_item_t         result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [DIST_W-1:0] cfg_data;

	int errors;
	int outstanding;
	int rays_checked;
	int walls_hit;
	int idle_cycles;
	int items_sent;
	int writes_sent;
	int limits_set;
	int rx_hold;
	bit tx_burst;
	bit rx_burst;

	always #5 clk = ~clk;

	grid_ray_march_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	grid_ray_march_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.pop          (pop),
		.empty        (empty),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.outstanding  (outstanding),
		.rays_checked (rays_checked),
		.walls_hit    (walls_hit)
	);

	// cycles with no handshake on any channel
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", STALL_LIMIT);
			$display("grid_ray_march_core_test NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side
	initial begin
		int gap;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0)
				rx_burst = !rx_burst;
			gap = rx_burst ? 0 : $urandom_range(0, 15);
			if (rx_hold != 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end
			if (gap != 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	function automatic in_item_t noise_item();
		in_item_t it;
		it.cmd = 1'($urandom_range(0, 1));
		it.cell_x = 5'($urandom_range(0, 31));
		it.cell_y = 5'($urandom_range(0, 31));
		it.cell_value = 8'($urandom_range(0, 255));
		it.start_x = 19'($urandom_range(0, 524287));
		it.start_y = 19'($urandom_range(0, 524287));
		it.ray_angle = 10'($urandom_range(0, 1023));
		return it;
	endfunction

	task automatic send_request(input in_item_t it);
		int gap;
		if ($urandom_range(0, 31) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (it.cmd == CMD_WRITE)
			writes_sent++;
	endtask

	task automatic put_cell(input logic [4:0] x, input logic [4:0] y, input logic [7:0] v);
		in_item_t it;
		it = noise_item();
		it.cmd = CMD_WRITE;
		it.cell_x = x;
		it.cell_y = y;
		it.cell_value = v;
		send_request(it);
	endtask

	task automatic cast_ray(input logic [XY_W-1:0] sx, input logic [XY_W-1:0] sy,
		input logic [ANG_W-1:0] ang);
		in_item_t it;
		it = noise_item();
		it.cmd = CMD_CAST;
		it.start_x = sx;
		it.start_y = sy;
		it.ray_angle = ang;
		send_request(it);
	endtask

	// stop offering, let every ray come back, then give queued tile writes time to land
	task automatic wait_quiet();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_step_limit(input int lim);
		wait_quiet();
		cfg_valid <= 1'b1;
		cfg_data <= DIST_W'(lim);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		limits_set++;
	endtask

	initial begin
		int phase;
		int lim;
		int batch;
		int pick;
		push <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// open map at the reset step limit, then a west wall
		cast_ray(MID, MID, 10'd0);
		put_cell(5'd0, 5'd16, 8'd255);
		cast_ray(MID, MID, 10'd0);
		// first sample already negative, and leaving the east edge at once
		cast_ray(19'd0, 19'd0, 10'd0);
		cast_ray('1, '1, 10'd512);
		// origin inside a wall, marching away from it
		cast_ray(19'd16383, MID, 10'd512);
		put_cell(5'd31, 5'd31, 8'd1);
		cast_ray(19'd400000, 19'd400000, 10'd640);
		cast_ray(MID, 19'd8192, 10'd256);
		cast_ray(MID, MID, 10'd768);
		cast_ray(MID, MID, 10'd1023);
		cast_ray(MID, MID, 10'd128);
		put_cell(5'd0, 5'd16, 8'd0);
		cast_ray(MID, MID, 10'd0);
		// limits of zero and one take no step, two reaches the corner wall
		set_step_limit(0);
		cast_ray(NEAR_CORNER, NEAR_CORNER, 10'd640);
		set_step_limit(1);
		cast_ray(NEAR_CORNER, NEAR_CORNER, 10'd640);
		set_step_limit(2);
		cast_ray(NEAR_CORNER, NEAR_CORNER, 10'd640);
		set_step_limit(1023);
		cast_ray(MID, MID, 10'd0);
		cast_ray(NEAR_CORNER, NEAR_CORNER, 10'd896);

		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase % 6)
				0: lim = 1023;
				1: lim = $urandom_range(2, 1023);
				2: lim = $urandom_range(2, 80);
				3: lim = 1000;
				4: lim = $urandom_range(0, 3);
				default: lim = $urandom_range(0, 1023);
			endcase
			set_step_limit(lim);
			// results back up while rays keep coming
			if (phase == 2)
				rx_hold = HOLD_CYCLES;
			batch = $urandom_range(50, 90);
			repeat (batch) begin
				pick = $urandom_range(0, 99);
				if (pick < 35)
					put_cell(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
						($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
				else if (pick < 95)
					cast_ray(19'($urandom_range(0, 524287)), 19'($urandom_range(0, 524287)),
						10'($urandom_range(0, 1023)));
				else
					send_request(noise_item());
			end
			phase++;
		end

		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests (%0d tile writes), %0d rays checked, %0d of them hit a wall",
			items_sent, writes_sent, rays_checked, walls_hit);
		$display("%0d step limits programmed, including 0, 1, 2 and 1023", limits_set);
		if (errors == 0 && outstanding == 0) begin
			$display("grid_ray_march_core_test OK");
		end else begin
			$display("grid_ray_march_core_test NOT OK");
		end
		$finish;
	end

endmodule
